[hw/rtl/bfbc_pkg.sv]
// bfbc_pkg: shared types, codes and constants of the balance factor calibrator
// used by bfbc_div, bfbc_dp, bfbc_ctrl and the top level
// no dependencies

package bfbc_pkg;

   // number formats
   localparam int FRAC_BITS   = 16;
   localparam int THRUST_W    = 16;
   localparam int FACTOR_W    = FRAC_BITS + 1;
   localparam int PROD_W      = THRUST_W + FACTOR_W;
   localparam int ANGLE_W     = 16;
   localparam int CONF_W      = 15;
   localparam int ROUND_W     = 5;
   localparam int PAUSE_W     = 4;
   localparam int INTERVAL_W  = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DATA_W  = 64;

   localparam logic [FACTOR_W-1:0] ONE_Q      = FACTOR_W'(1) << FRAC_BITS;
   localparam logic [FACTOR_W-1:0] HALF_Q     = FACTOR_W'(1) << (FRAC_BITS - 1);
   localparam logic [THRUST_W-1:0] THRUST_MAX = '1;
   localparam logic [ROUND_W-1:0]  MAX_ROUNDS = ROUND_W'(16);

   // iterative divider: one quotient bit a cycle
   localparam int DIV_STEPS = THRUST_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   // register reset values
   localparam logic [15:0]           RST_MAX_THRUST    = 16'd19661;
   localparam logic [15:0]           RST_RAMP_STEP     = 16'd655;
   localparam logic [INTERVAL_W-1:0] RST_RAMP_INTERVAL = 8'd5;
   localparam logic [15:0]           RST_START_THRUST  = 16'd9175;
   localparam logic [CONF_W-1:0]     RST_CONFIRM_ANGLE = 15'd143;
   localparam logic [CONF_W-1:0]     RST_REST_ANGLE    = 15'd72;
   localparam logic [ROUND_W-1:0]    RST_ROUND_COUNT   = 5'd7;
   localparam logic [PAUSE_W-1:0]    RST_PAUSE_TICKS   = 4'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_THRUST    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RAMP_STEP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RAMP_INTERVAL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_START_THRUST  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CONFIRM_ANGLE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_REST_ANGLE    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ROUND_COUNT   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_PAUSE_TICKS   = 3'd7;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_START  = 2'd2,
      CMD_STOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_RAMP   = 3'd1,
      PH_RETURN = 3'd2,
      PH_PAUSE  = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      VERDICT_NONE  = 2'd0,
      VERDICT_BIG   = 2'd1,
      VERDICT_SMALL = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_SEND
   } ctrl_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic step;      // apply the accepted word to the calibration state
      logic mul;       // register thrust * (1 - f)
      logic load;      // load the divider, latch saturation flags
      logic div_step;  // one quotient bit
      logic send;      // load the result word into the output register
   } dp_cmd_type;

endpackage

[hw/rtl/bfbc_div.sv]
// bfbc_div: restoring divider, one quotient bit per step
// expects the upper half of the dividend below the divisor; uses bfbc_pkg

module bfbc_div (
   input  logic                             clock,
   input  logic                             load,
   input  logic                             step,
   input  logic [bfbc_pkg::PROD_W-1:0]      dividend,
   input  logic [bfbc_pkg::FACTOR_W-1:0]    divisor,
   output logic [bfbc_pkg::THRUST_W-1:0]    quotient
);
   import bfbc_pkg::*;

   logic [FACTOR_W-1:0] rem_ff, rem_in;
   logic [THRUST_W-1:0] quo_ff, quo_in;
   logic [FACTOR_W:0]   trial;
   logic [FACTOR_W:0]   trial_diff;
   logic                fits;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      trial      = {rem_ff, quo_ff[THRUST_W-1]};
      trial_diff = trial - {1'b0, divisor};
      fits       = trial >= {1'b0, divisor};
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (load) begin
         rem_in = dividend[PROD_W-1:THRUST_W];
         quo_in = dividend[THRUST_W-1:0];
      end else if (step) begin
         rem_in = fits ? trial_diff[FACTOR_W-1:0] : trial[FACTOR_W-1:0];
         quo_in = {quo_ff[THRUST_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

[hw/rtl/bfbc_dp.sv]
// bfbc_dp: datapath with registers, calibration state, rear thrust unit, result word
// uses bfbc_pkg and bfbc_div

module bfbc_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bfbc_pkg::dp_cmd_type                 dp_cmd,
   input  logic [1:0]                           req_tuser,
   input  logic [bfbc_pkg::ANGLE_W-1:0]         req_tdata,
   input  logic                                 csr_write,
   input  logic [bfbc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bfbc_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic [bfbc_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import bfbc_pkg::*;

   // configuration registers
   logic [15:0]           max_thrust_ff, ramp_step_ff, start_thrust_ff;
   logic [INTERVAL_W-1:0] ramp_interval_ff;
   logic [CONF_W-1:0]     confirm_angle_ff, rest_angle_ff;
   logic [ROUND_W-1:0]    round_count_ff;
   logic [PAUSE_W-1:0]    pause_ticks_ff;

   // calibration state
   logic [FACTOR_W-1:0]   bound_low_ff, bound_low_in;
   logic [FACTOR_W-1:0]   bound_high_ff, bound_high_in;
   logic [FACTOR_W-1:0]   factor_ff, factor_in;
   logic [THRUST_W-1:0]   thrust_ff, thrust_in;
   phase_type             phase_ff, phase_in;
   logic [ROUND_W-1:0]    round_ff, round_in;
   logic [15:0]           secs_ff, secs_in;
   logic [15:0]           next_ramp_ff, next_ramp_in;
   logic [PAUSE_W-1:0]    pause_left_ff, pause_left_in;
   verdict_type           verdict_ff, verdict_in;

   // rear thrust unit
   logic [PROD_W-1:0]     prod_ff;
   logic                  sat_ff, zero_ff;
   logic [THRUST_W-1:0]   quotient;
   logic [THRUST_W-1:0]   rear;
   logic [FACTOR_W-1:0]   one_minus_f;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // step helpers
   cmd_type               cmd;
   logic signed [ANGLE_W:0] pitch_x, conf_x, conf_neg, rest_x, rest_neg;
   logic [FACTOR_W:0]     bound_sum;
   logic [FACTOR_W-1:0]   mid_cur;
   logic [ROUND_W-1:0]    rounds_lim;
   logic [ROUND_W-1:0]    rnd_next;
   logic                  begin_rnd;
   logic                  start_bounds;
   logic [16:0]           ramp_sum, thrust_sum;
   logic [PAUSE_W-1:0]    pause_dec;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_thrust_ff    <= RST_MAX_THRUST;
         ramp_step_ff     <= RST_RAMP_STEP;
         ramp_interval_ff <= RST_RAMP_INTERVAL;
         start_thrust_ff  <= RST_START_THRUST;
         confirm_angle_ff <= RST_CONFIRM_ANGLE;
         rest_angle_ff    <= RST_REST_ANGLE;
         round_count_ff   <= RST_ROUND_COUNT;
         pause_ticks_ff   <= RST_PAUSE_TICKS;
      end else if (csr_write) begin
         case (csr_index)
            REG_MAX_THRUST:    max_thrust_ff    <= csr_data;
            REG_RAMP_STEP:     ramp_step_ff     <= csr_data;
            REG_RAMP_INTERVAL: ramp_interval_ff <= csr_data[INTERVAL_W-1:0];
            REG_START_THRUST:  start_thrust_ff  <= csr_data;
            REG_CONFIRM_ANGLE: confirm_angle_ff <= csr_data[CONF_W-1:0];
            REG_REST_ANGLE:    rest_angle_ff    <= csr_data[CONF_W-1:0];
            REG_ROUND_COUNT:   round_count_ff   <= csr_data[ROUND_W-1:0];
            REG_PAUSE_TICKS:   pause_ticks_ff   <= csr_data[PAUSE_W-1:0];
            default: ;
         endcase
      end
   end

   // operands of the step
   always_comb begin
      cmd        = cmd_type'(req_tuser);
      pitch_x    = {req_tdata[ANGLE_W-1], req_tdata};
      conf_x     = {2'b00, confirm_angle_ff};
      conf_neg   = -conf_x;
      rest_x     = {2'b00, rest_angle_ff};
      rest_neg   = -rest_x;
      bound_sum  = {1'b0, bound_low_ff} + {1'b0, bound_high_ff};
      mid_cur    = bound_sum[FACTOR_W:1];
      rounds_lim = (round_count_ff > MAX_ROUNDS) ? MAX_ROUNDS : round_count_ff;
      ramp_sum   = {1'b0, next_ramp_ff} + {9'b0, ramp_interval_ff};
      thrust_sum = {1'b0, thrust_ff} + {1'b0, ramp_step_ff};
      pause_dec  = (pause_left_ff != '0) ? pause_left_ff - PAUSE_W'(1) : '0;
   end

   // next calibration state for one accepted word
   always_comb begin
      bound_low_in  = bound_low_ff;
      bound_high_in = bound_high_ff;
      factor_in     = factor_ff;
      thrust_in     = thrust_ff;
      phase_in      = phase_ff;
      round_in      = round_ff;
      secs_in       = secs_ff;
      next_ramp_in  = next_ramp_ff;
      pause_left_in = pause_left_ff;
      verdict_in    = VERDICT_NONE;
      begin_rnd     = 1'b0;
      start_bounds  = 1'b0;
      rnd_next      = round_ff;

      case (cmd)
         CMD_START: begin
            bound_low_in  = '0;
            bound_high_in = ONE_Q;
            begin_rnd     = 1'b1;
            start_bounds  = 1'b1;
            rnd_next      = '0;
         end
         CMD_STOP: begin
            thrust_in = '0;
            phase_in  = PH_IDLE;
         end
         CMD_TICK: begin
            if (phase_ff == PH_RAMP) begin
               if (secs_ff != 16'hFFFF) secs_in = secs_ff + 16'd1;
            end else if (phase_ff == PH_PAUSE) begin
               pause_left_in = pause_dec;
               if (pause_dec == '0) begin
                  begin_rnd = 1'b1;
                  rnd_next  = round_ff + ROUND_W'(1);
               end
            end
         end
         CMD_SAMPLE: begin
            if (phase_ff == PH_RAMP) begin
               if (pitch_x > conf_x) begin
                  bound_high_in = factor_ff;
                  verdict_in    = VERDICT_BIG;
                  thrust_in     = start_thrust_ff;
                  phase_in      = PH_RETURN;
               end else if (pitch_x < conf_neg) begin
                  bound_low_in = factor_ff;
                  verdict_in   = VERDICT_SMALL;
                  thrust_in    = start_thrust_ff;
                  phase_in     = PH_RETURN;
               end else if (secs_ff > next_ramp_ff && thrust_ff < max_thrust_ff) begin
                  next_ramp_in = ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
                  thrust_in    = thrust_sum[16] ? THRUST_MAX : thrust_sum[15:0];
               end
            end else if (phase_ff == PH_RETURN) begin
               if (pitch_x < rest_x && pitch_x > rest_neg) begin
                  if (pause_ticks_ff == '0) begin
                     begin_rnd = 1'b1;
                     rnd_next  = round_ff + ROUND_W'(1);
                  end else begin
                     pause_left_in = pause_ticks_ff;
                     phase_in      = PH_PAUSE;
                  end
               end
            end
         end
         default: ;
      endcase

      // round start, or done once all rounds have run
      if (begin_rnd) begin
         round_in = rnd_next;
         if (rnd_next >= rounds_lim) begin
            phase_in  = PH_DONE;
            thrust_in = '0;
         end else begin
            factor_in    = start_bounds ? HALF_Q : mid_cur;
            thrust_in    = start_thrust_ff;
            secs_in      = '0;
            next_ramp_in = {8'b0, ramp_interval_ff};
            phase_in     = PH_RAMP;
         end
      end
   end

   // calibration state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bound_low_ff  <= '0;
         bound_high_ff <= ONE_Q;
         factor_ff     <= HALF_Q;
         thrust_ff     <= '0;
         phase_ff      <= PH_IDLE;
         round_ff      <= '0;
         secs_ff       <= '0;
         next_ramp_ff  <= '0;
         pause_left_ff <= '0;
         verdict_ff    <= VERDICT_NONE;
      end else if (dp_cmd.step) begin
         bound_low_ff  <= bound_low_in;
         bound_high_ff <= bound_high_in;
         factor_ff     <= factor_in;
         thrust_ff     <= thrust_in;
         phase_ff      <= phase_in;
         round_ff      <= round_in;
         secs_ff       <= secs_in;
         next_ramp_ff  <= next_ramp_in;
         pause_left_ff <= pause_left_in;
         verdict_ff    <= verdict_in;
      end
   end

   // rear thrust: T * (1 - f) / f, saturated
   assign one_minus_f = ONE_Q - factor_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.mul) prod_ff <= {1'b0, thrust_ff} * {16'b0, one_minus_f};
      if (dp_cmd.load) begin
         zero_ff <= (thrust_ff == '0);
         sat_ff  <= (prod_ff[PROD_W-1:THRUST_W] >= factor_ff);
      end
   end

   bfbc_div u_div (
      .clock    (clock),
      .load     (dp_cmd.load),
      .step     (dp_cmd.div_step),
      .dividend (prod_ff),
      .divisor  (factor_ff),
      .quotient (quotient)
   );

   assign rear = zero_ff ? '0 : (sat_ff ? THRUST_MAX : quotient);

   // result word
   always_ff @(posedge clock) begin
      if (dp_cmd.send) begin
         rsp_data_ff <= {5'b0, verdict_ff, round_ff, phase_ff, factor_ff, rear, thrust_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

[hw/rtl/bfbc_ctrl.sv]
// bfbc_ctrl: sequencer for step, multiply, divide and result hand-off
// uses bfbc_pkg

module bfbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output bfbc_pkg::dp_cmd_type dp_cmd
);
   import bfbc_pkg::*;

   ctrl_state_type        state_ff, state_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      dp_cmd     = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd.step = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            dp_cmd.mul = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            dp_cmd.load = 1'b1;
            cnt_in      = '0;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            dp_cmd.div_step = 1'b1;
            cnt_in          = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_LAST) state_in = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               dp_cmd.send = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register valid
   always_comb begin
      if (dp_cmd.send)     rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

   // an accepted word always starts the multiply next
   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_MUL))
      else $error("accepted word did not start the multiply");

   // the divider runs exactly its step count before the hand-off
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> ##(DIV_STEPS) (state_ff == ST_SEND))
      else $error("divider sequence has the wrong length");

   // a pending result word is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !dp_cmd.send)
      else $error("result word overwritten while stalled");

   // no new word is taken while a result is being computed
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.mul || dp_cmd.load || dp_cmd.div_step) |-> !req_tready)
      else $error("input taken while a word is in flight");

endmodule

[hw/rtl/balance_factor_bisection_calibrator.sv]
// balance_factor_bisection_calibrator: top level of the bisection balance calibrator
// instantiates bfbc_ctrl and bfbc_dp; uses bfbc_pkg
//
// usage
// - req channel: one word per command; req_tuser carries the command (attitude
//   sample, one-second tick, start, stop), req_tdata the signed pitch
// - rsp channel: one result word per request word with front and rear thrust,
//   current factor, phase, round and the verdict of that word
// - csr channel: register index and data, always ready; write only while no
//   word is in flight
// - flow: one word is in flight at a time; each accepted word runs through the
//   step, multiply, divider load, the bit-serial divider for the rear thrust
//   and the hand-off before a new word is taken
// - the result sits in an output register, so the next request is taken
//   while a result still waits for rsp_tready
// - receiver stall: the block finishes the word in flight and holds in the
//   hand-off state until the output register frees up
// - reset: synchronous; registers return to their defaults, the calibration
//   goes idle with the factor at one half, no result is pending

module balance_factor_bisection_calibrator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bfbc_pkg::ANGLE_W-1:0]        req_tdata,   // [15:0] pitch
   input  logic [1:0]                          req_tuser,   // [1:0] command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] front_thrust, [31:16] rear_thrust, [48:32] balance_factor,
   // [51:49] phase, [56:52] round_index, [58:57] verdict, [63:59] zero
   output logic [bfbc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bfbc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bfbc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bfbc_pkg::*;

   dp_cmd_type dp_cmd;
   logic       csr_write;

   // registers take a write every cycle
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   bfbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd)
   );

   bfbc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule
